@@ sv/drrip_reuse_stream_replacement_core_defines.svh @@
// Assertion macros shared by the replacement core checker
`ifndef DRRIP_REUSE_STREAM_REPLACEMENT_CORE_DEFINES_SVH
`define DRRIP_REUSE_STREAM_REPLACEMENT_CORE_DEFINES_SVH

// Check a property outside reset
`define DRRIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included
`define DRRIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/drrip_pkg.sv @@
// Types and constants shared by the replacement core modules
package drrip_pkg;

   localparam int ADDR_W   = 48;
   localparam int SET_IN_W = 11;
   localparam int WAY_IN_W = 4;
   localparam int MASK_W   = 16;
   localparam int DRAW_W   = 5;

   localparam logic ACT_VICTIM = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   localparam logic [1:0] RRPV_MAX     = 2'd3;
   localparam logic [1:0] RRPV_LONG    = 2'd2;
   localparam logic [1:0] RRPV_NEAR    = 2'd0;
   localparam logic [1:0] REUSE_MAX    = 2'd3;
   localparam logic [1:0] REUSE_STRONG = 2'd2;
   localparam logic [1:0] REUSE_INIT   = 2'd1;

   localparam logic [ADDR_W-1:0] STRIDE_RESET = 48'd4096;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
      logic rsp_blocked;
   } status_type;

endpackage

@@ sv/drrip_reuse_stream_replacement_core.sv @@
// Top level of the set-dueling replacement core
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | action, set, way, hit, address, mask, draw
//  rsp_    | out       | rsp_valid/rsp_stall  | victim_way
//  csr_    | in        | csr_wr_en            | stride threshold, 48 bits
//
// Each item starts with a registered read of the set row; the row is then computed
// and written back through the single write port of the row memories.
// After reset a clearing pass writes one set per cycle until all NUM_SETS sets are
// written, and no item is taken meanwhile; csr writes are taken throughout.
// A victim result waits in the output register; while it sits there stalled, the
// next item of either kind holds in execution and no further item is taken.
module drrip_reuse_stream_replacement_core #(
   parameter int NUM_SETS      = 2048,
   parameter int NUM_WAYS      = 16,
   parameter int LEADER_SETS   = 64,
   parameter int SELECTOR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [drrip_pkg::SET_IN_W-1:0]      req_set_index,
   input  logic [drrip_pkg::WAY_IN_W-1:0]      req_way_index,
   input  logic                                req_was_hit,
   input  logic [drrip_pkg::ADDR_W-1:0]        req_address,
   input  logic [drrip_pkg::MASK_W-1:0]        req_valid_mask,
   input  logic [drrip_pkg::DRAW_W-1:0]        req_random_draw,
   input  logic                                csr_wr_en,
   input  logic [drrip_pkg::ADDR_W-1:0]        csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [drrip_pkg::WAY_IN_W-1:0]      rsp_victim_way
);
   import drrip_pkg::*;

   cmd_type    cmd;
   status_type status;

   drrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   drrip_dpath #(
      .NUM_SETS      (NUM_SETS),
      .NUM_WAYS      (NUM_WAYS),
      .LEADER_SETS   (LEADER_SETS),
      .SELECTOR_BITS (SELECTOR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_set_index   (req_set_index),
      .req_way_index   (req_way_index),
      .req_was_hit     (req_was_hit),
      .req_address     (req_address),
      .req_valid_mask  (req_valid_mask),
      .req_random_draw (req_random_draw),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_victim_way  (rsp_victim_way)
   );

endmodule

@@ sv/drrip_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module drrip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/drrip_ctrl.sv @@
// Controller: clearing pass, item acceptance and execution sequencing
module drrip_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  drrip_pkg::status_type  status,
   output drrip_pkg::cmd_type     cmd
);
   import drrip_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   // Decode commands from state
   always_comb begin
      cmd        = '0;
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.exec   = (state_ff == ST_EXEC) && !status.rsp_blocked;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!status.rsp_blocked) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/drrip_dpath.sv @@
// Datapath: set metadata memories, victim selection, insertion and selector
module drrip_dpath #(
   parameter int NUM_SETS      = 2048,
   parameter int NUM_WAYS      = 16,
   parameter int LEADER_SETS   = 64,
   parameter int SELECTOR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drrip_pkg::cmd_type                  cmd,
   output drrip_pkg::status_type               status,
   input  logic                                req_action,
   input  logic [drrip_pkg::SET_IN_W-1:0]      req_set_index,
   input  logic [drrip_pkg::WAY_IN_W-1:0]      req_way_index,
   input  logic                                req_was_hit,
   input  logic [drrip_pkg::ADDR_W-1:0]        req_address,
   input  logic [drrip_pkg::MASK_W-1:0]        req_valid_mask,
   input  logic [drrip_pkg::DRAW_W-1:0]        req_random_draw,
   input  logic                                csr_wr_en,
   input  logic [drrip_pkg::ADDR_W-1:0]        csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [drrip_pkg::WAY_IN_W-1:0]      rsp_victim_way
);
   import drrip_pkg::*;

   localparam int SW = $clog2(NUM_SETS);
   localparam int RW = 2 * NUM_WAYS;
   localparam int XW = 17;
   localparam int EW = 6;
   localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
   localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;

   // Held item
   logic                act_ff;
   logic [SW-1:0]       set_ff;
   logic [WAY_IN_W-1:0] way_ff;
   logic                hit_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [DRAW_W-1:0]   draw_ff;

   logic [ADDR_W-1:0]        thresh_ff;
   logic [SELECTOR_BITS-1:0] psel_ff, psel_in;
   logic [SW-1:0]            clr_cnt_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WAY_IN_W-1:0]      rsp_way_ff;

   logic [XW-1:0] set_in_ext;
   logic [SW-1:0] set_in;

   // Memory ports
   logic          row_wr_en, addr_wr_en;
   logic [SW-1:0] wr_addr;
   logic [RW-1:0] rrpv_rd, reuse_rd, rrpv_wr, reuse_wr;
   logic [RW-1:0] rrpv_new, reuse_new, rrpv_rst, reuse_rst;
   logic [ADDR_W-1:0] last_rd, last_wr;

   // Working signals
   logic [NUM_WAYS+MASK_W-1:0] mask_ext;
   logic                any_inv, any3, anyb1, anyb0;
   logic [WAY_IN_W-1:0] first_inv, first3;
   logic [1:0]          top, rv, aged_v;
   logic [RW-1:0]       aged;
   logic [ADDR_W:0]     diff;
   logic [ADDR_W-1:0]   delta;
   logic                streaming, srrip, brrip, way_ok, is_update;
   logic [XW-1:0]       set_ext;
   logic [EW-1:0]       way_ext;
   logic [1:0]          bimodal, ins_base, ins, reuse_sel;

   assign set_in_ext = XW'(req_set_index);
   assign set_in     = set_in_ext[SW-1:0];

   // Capture item on acceptance, and the victim way when a victim item executes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff  <= req_action;
         set_ff  <= set_in;
         way_ff  <= req_way_index;
         hit_ff  <= req_was_hit;
         addr_ff <= req_address;
         mask_ff <= req_valid_mask;
         draw_ff <= req_random_draw;
      end
      if (cmd.exec && act_ff == ACT_VICTIM) begin
         rsp_way_ff <= any_inv ? first_inv : first3;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= STRIDE_RESET;
         psel_ff      <= SEL_HALF;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) thresh_ff <= csr_wr_data;
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         psel_ff      <= psel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Victim search over the read row
   always_comb begin
      mask_ext  = (NUM_WAYS + MASK_W)'(mask_ff);
      any_inv   = 1'b0;
      any3      = 1'b0;
      anyb1     = 1'b0;
      anyb0     = 1'b0;
      first_inv = '0;
      first3    = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!mask_ext[w]) begin
            any_inv   = 1'b1;
            first_inv = WAY_IN_W'(w);
         end
         rv = rrpv_rd[2*w +: 2];
         if (rv == RRPV_MAX) any3 = 1'b1;
         if (rv[1]) anyb1 = 1'b1;
         if (rv[0]) anyb0 = 1'b1;
      end
      top = anyb1 ? (any3 ? RRPV_MAX : RRPV_LONG) : {1'b0, anyb0};
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         aged_v         = 2'(rrpv_rd[2*w +: 2] + (RRPV_MAX - top));
         aged[2*w +: 2] = aged_v;
         if (aged_v == RRPV_MAX) first3 = WAY_IN_W'(w);
      end
   end

   // Streaming detection and insertion choice
   always_comb begin
      diff      = {1'b0, addr_ff} - {1'b0, last_rd};
      if (last_rd == '0)  delta = '0;
      else if (!diff[ADDR_W]) delta = diff[ADDR_W-1:0];
      else delta = last_rd - addr_ff;
      streaming = (delta >= thresh_ff);
      set_ext   = XW'(set_ff);
      srrip     = set_ext < XW'(LEADER_SETS / 2);
      brrip     = !srrip && (set_ext < XW'(LEADER_SETS));
      bimodal   = (draw_ff == '0) ? RRPV_LONG : RRPV_MAX;
      if (srrip) ins_base = RRPV_LONG;
      else if (brrip) ins_base = bimodal;
      else ins_base = (psel_ff >= SEL_HALF) ? RRPV_LONG : bimodal;
      way_ext   = EW'(way_ff);
      way_ok    = way_ext < EW'(NUM_WAYS);
      is_update = (act_ff == ACT_UPDATE) && way_ok;
      reuse_sel = REUSE_INIT;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (way_ext == EW'(w)) reuse_sel = reuse_rd[2*w +: 2];
      end
      ins = streaming ? RRPV_MAX : ins_base;
      if (reuse_sel >= REUSE_STRONG) ins = RRPV_NEAR;
   end

   // New row contents
   always_comb begin
      rrpv_new  = rrpv_rd;
      reuse_new = reuse_rd;
      if (act_ff == ACT_VICTIM) begin
         if (!any_inv) rrpv_new = aged;
      end else if (is_update) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_ext == EW'(w)) begin
               if (hit_ff) begin
                  rrpv_new[2*w +: 2]  = RRPV_NEAR;
                  reuse_new[2*w +: 2] = (reuse_sel < REUSE_MAX) ? 2'(reuse_sel + 2'd1)
                                                                 : reuse_sel;
               end else begin
                  rrpv_new[2*w +: 2]  = ins;
                  reuse_new[2*w +: 2] = REUSE_INIT;
               end
            end
         end
      end
   end

   // Selector update on misses in leader sets
   always_comb begin
      psel_in = psel_ff;
      if (cmd.exec && is_update && !hit_ff) begin
         if (srrip && psel_ff != '0) psel_in = psel_ff - 1'b1;
         else if (brrip && psel_ff != SEL_MAX) psel_in = psel_ff + 1'b1;
      end
   end

   // Result register: load on a victim item, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec && act_ff == ACT_VICTIM) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // Memory write selection
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         rrpv_rst[2*w +: 2]  = RRPV_MAX;
         reuse_rst[2*w +: 2] = REUSE_INIT;
      end
      row_wr_en  = cmd.clear || cmd.exec;
      addr_wr_en = cmd.clear || (cmd.exec && is_update);
      wr_addr    = cmd.clear ? clr_cnt_ff : set_ff;
      rrpv_wr    = cmd.clear ? rrpv_rst : rrpv_new;
      reuse_wr   = cmd.clear ? reuse_rst : reuse_new;
      last_wr    = cmd.clear ? '0 : addr_ff;
   end

   drrip_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_rrpv_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (wr_addr),
      .wr_data (rrpv_wr),
      .rd_en   (cmd.accept),
      .rd_addr (set_in),
      .rd_data (rrpv_rd)
   );

   drrip_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_reuse_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (wr_addr),
      .wr_data (reuse_wr),
      .rd_en   (cmd.accept),
      .rd_addr (set_in),
      .rd_data (reuse_rd)
   );

   drrip_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_SETS)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (wr_addr),
      .wr_data (last_wr),
      .rd_en   (cmd.accept),
      .rd_addr (set_in),
      .rd_data (last_rd)
   );

   always_comb begin
      status             = '0;
      status.clear_done  = (clr_cnt_ff == SW'(NUM_SETS - 1));
      status.rsp_blocked = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

endmodule

@@ sv/drrip_checker.sv @@
// Port-level checker for the replacement core, with its bind
`include "drrip_reuse_stream_replacement_core_defines.svh"

module drrip_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_action,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [drrip_pkg::WAY_IN_W-1:0] rsp_victim_way
);
   import drrip_pkg::*;

   `DRRIP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")
   `DRRIP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_victim_way), "stalled result changed")
   `DRRIP_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "item taken on consecutive cycles")
   `DRRIP_ASSERT(a_rsp_from_victim, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && (req_action == ACT_VICTIM), 2), "result without a victim item")

endmodule

bind drrip_reuse_stream_replacement_core drrip_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_victim_way (rsp_victim_way)
);
